// ===== rtl/swm_pkg.sv =====
// Shared constants and controller/datapath interface types for the sliding window median block.
package swm_pkg;

	localparam int SAMPLE_W        = 32;
	localparam int MEDIAN_W        = 33;
	localparam int CFG_W           = 7;
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int WINDOW_SIZE_RST = 3;

	typedef struct packed {
		logic load;
		logic remove;
		logic insert;
		logic pick;
		logic push;
	} swm_cmd_t;

	typedef struct packed {
		logic full_in;
		logic out_busy;
		logic full;
	} swm_sts_t;

endpackage

// ===== rtl/swm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/swm_ctrl.sv =====
// Sliding window median sequencer: load, remove if full, insert, pick, push if a result is due.
module swm_ctrl import swm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  swm_sts_t sts,
	output swm_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REMOVE = 3'd1;
	localparam logic [2:0] ST_INSERT = 3'd2;
	localparam logic [2:0] ST_PICK   = 3'd3;
	localparam logic [2:0] ST_PUSH   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.full_in ? ST_REMOVE : ST_INSERT;
				end
			end
			ST_REMOVE: begin
				cmd.remove = 1'b1;
				state_nxt  = ST_INSERT;
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				state_nxt  = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick  = 1'b1;
				// the fill count already includes this sample here
				state_nxt = sts.full ? ST_PUSH : ST_IDLE;
			end
			ST_PUSH: begin
				// hold until the output register frees up
				if (!sts.out_busy) begin
					cmd.push  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/swm_dp.sv =====
// Datapath: arrival ring, sorted cell row, window counters, median sum and output register.
module swm_dp import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic [SAMPLE_W-1:0]        sample,
	input  logic                       first_sample,
	output logic signed [MEDIAN_W-1:0] median_times_two,
	output logic                       out_valid,
	input  logic                       out_stall,
	input  swm_cmd_t                   cmd,
	output swm_sts_t                   sts
);

	localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int KW = $clog2(WINDOW_MAX + 1);
	localparam int SB = SAMPLE_BITS;
	localparam int K_RST = (WINDOW_SIZE_RST > WINDOW_MAX) ? WINDOW_MAX : WINDOW_SIZE_RST;

	logic [KW-1:0]        k_q;
	logic [KW-1:0]        k_cfg;
	logic [KW-1:0]        fill_q;
	logic [PW-1:0]        ptr_q;
	logic                 was_full_q;
	logic signed [SB-1:0] sample_q;
	logic [PW-1:0]        ram_raddr;
	logic [SB-1:0]        ram_rdata;
	logic [KW-1:0]        ins_n;
	logic [KW-1:0]        ptr_inc;
	logic                 full_now;

	logic signed [SB-1:0] cell_q   [WINDOW_MAX];
	logic signed [SB-1:0] cell_rm  [WINDOW_MAX];
	logic signed [SB-1:0] cell_ins [WINDOW_MAX];
	logic [WINDOW_MAX-1:0] match;
	logic [WINDOW_MAX-1:0] seen;
	logic [WINDOW_MAX-1:0] gt;

	logic [PW-1:0]        idx_hi;
	logic [PW-1:0]        idx_lo;
	logic signed [SB-1:0] mid_lo_q;
	logic signed [SB-1:0] mid_hi_q;
	logic signed [SB:0]   mid_sum;

	// clamp the written window size into 1..WINDOW_MAX
	always_comb begin
		if (cfg_wdata == '0) begin
			k_cfg = KW'(1);
		end else if (int'(cfg_wdata) > WINDOW_MAX) begin
			k_cfg = KW'(WINDOW_MAX);
		end else begin
			k_cfg = KW'(cfg_wdata);
		end
	end

	assign full_now     = (fill_q == k_q);
	assign sts.full_in  = !first_sample && full_now;
	assign sts.out_busy = out_valid && out_stall;
	assign sts.full     = full_now;
	assign ram_raddr    = first_sample ? '0 : ptr_q;
	assign ins_n        = was_full_q ? (k_q - KW'(1)) : fill_q;
	assign ptr_inc      = KW'(ptr_q) + KW'(1);

	swm_ram #(
		.WIDTH (SB),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (cmd.insert),
		.waddr (ptr_q),
		.wdata (sample_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		assign match[i] = (KW'(i) < k_q) && (cell_q[i] == $signed(ram_rdata));
		assign gt[i]    = (KW'(i) >= ins_n) || (cell_q[i] > sample_q);

		if (i == 0) begin : g_first
			assign seen[i]     = match[i];
			assign cell_ins[i] = gt[i] ? sample_q : cell_q[i];
		end else begin : g_rest
			assign seen[i]     = seen[i-1] | match[i];
			// shift up past the insertion point, drop the new sample at it
			assign cell_ins[i] = gt[i-1] ? cell_q[i-1] : (gt[i] ? sample_q : cell_q[i]);
		end

		if (i == WINDOW_MAX - 1) begin : g_last
			assign cell_rm[i] = cell_q[i];
		end else begin : g_mid
			// close the gap left by the leaving sample
			assign cell_rm[i] = seen[i] ? cell_q[i+1] : cell_q[i];
		end

		always_ff @(posedge clk) begin
			if (cmd.remove) begin
				cell_q[i] <= cell_rm[i];
			end else if (cmd.insert) begin
				cell_q[i] <= cell_ins[i];
			end
		end
	end

	assign idx_hi  = PW'(k_q >> 1);
	assign idx_lo  = k_q[0] ? idx_hi : (idx_hi - PW'(1));
	assign mid_sum = {mid_lo_q[SB-1], mid_lo_q} + {mid_hi_q[SB-1], mid_hi_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= $signed(sample[SB-1:0]);
		end
		if (cmd.pick) begin
			mid_lo_q <= cell_q[idx_lo];
			mid_hi_q <= cell_q[idx_hi];
		end
		if (cmd.push) begin
			median_times_two <= MEDIAN_W'(mid_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q        <= KW'(K_RST);
			fill_q     <= '0;
			ptr_q      <= '0;
			was_full_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				k_q    <= k_cfg;
				fill_q <= '0;
				ptr_q  <= '0;
			end else if (cmd.load) begin
				was_full_q <= sts.full_in;
				if (first_sample) begin
					fill_q <= '0;
					ptr_q  <= '0;
				end
			end else if (cmd.insert) begin
				if (!was_full_q) begin
					fill_q <= fill_q + KW'(1);
				end
				ptr_q <= (ptr_inc >= k_q) ? '0 : PW'(ptr_inc);
			end

			if (cmd.push) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/sliding_window_median_core.sv =====
// Sliding window median filter top level: sequencer, datapath and checks.
//
// Input channel: sample and first_sample move on a beat where in_valid is high
// and in_stall is low. first_sample empties the window before its sample is taken.
// Output channel: median_times_two (twice the window median) moves on a beat where
// out_valid is high and out_stall is low. No result comes until the window has
// filled with window_size samples; after that every sample yields one result.
// Configuration: cfg_wen with cfg_wdata writes window_size (0 acts as 1, values
// above WINDOW_MAX saturate) and empties the window. Write only while idle.
// Sequence: with the window full an item is accepted, the oldest sample is removed
// from the sorted cell row, the new one is inserted, the middle cells are picked,
// and the output register and out_valid are loaded together. While filling the
// remove step is skipped, and the load comes only on the sample that completes the window.
// The sequencer handles one sample at a time; the cell row passes set the rate.
// Reset: window_size returns to 3, the window is empty, out_valid is low.
// A stalled result holds in the output register; the next sample can be taken
// meanwhile, and the sequencer waits at the output load until the register frees.
module sliding_window_median_core import swm_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [CFG_W-1:0]           cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [SAMPLE_W-1:0]        sample,
	input  logic                       first_sample,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [MEDIAN_W-1:0] median_times_two
);

	swm_cmd_t cmd;
	swm_sts_t sts;

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	swm_dp #(
		.WINDOW_MAX  (WINDOW_MAX),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.sample           (sample),
		.first_sample     (first_sample),
		.median_times_two (median_times_two),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.cmd              (cmd),
		.sts              (sts)
	);

	// an accepted beat always starts a multi-cycle pass
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted back to back");

	// a new result is only loaded at the end of a pass
	a_result_from_pass: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a pass");

	// at most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.remove, cmd.insert, cmd.pick, cmd.push}))
		else $error("conflicting datapath commands");

	// the output register is never overwritten while its beat is stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(out_valid && out_stall))
		else $error("stalled result overwritten");

endmodule

// ===== tb/sliding_window_median_core_tb.sv =====
// Self-checking testbench for the sliding window median core with its own window predictor.
module sliding_window_median_core_tb import swm_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS  = 410;
	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT    = 2000;
	localparam int PRINT_LIMIT   = 20;

	localparam logic signed [MEDIAN_W-1:0] TWICE_MAX = 33'h0_ffff_fffe;
	localparam logic signed [MEDIAN_W-1:0] TWICE_MIN = 33'h1_0000_0000;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [SAMPLE_W-1:0]         value;
		logic                        first;
		logic                        pinned;
		logic signed [MEDIAN_W-1:0]  want;
	} stim_row_t;

	localparam int DIR_N = 30;
	localparam stim_row_t DIR_ROWS [DIR_N] = '{
		// reset window of three: extremes and duplicates
		'{ROW_ITEM, 32'h7fff_ffff, 1'b1, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'h0000_0000, 1'b0, 1'b1, 33'sd0},
		'{ROW_ITEM, 32'h7fff_ffff, 1'b0, 1'b1, 33'sd0},
		'{ROW_ITEM, 32'h7fff_ffff, 1'b0, 1'b1, TWICE_MAX},
		'{ROW_ITEM, 32'h8000_0000, 1'b1, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'h8000_0000, 1'b0, 1'b1, TWICE_MIN},
		'{ROW_ITEM, 32'd5,         1'b1, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd7,         1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd9,         1'b0, 1'b1, 33'sd14},
		'{ROW_CFG,  32'd1,         1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'h7fff_ffff, 1'b0, 1'b1, TWICE_MAX},
		'{ROW_ITEM, 32'hffff_ffff, 1'b0, 1'b1, -33'sd2},
		// zero acts as a window of one
		'{ROW_CFG,  32'd0,         1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd3,         1'b0, 1'b1, 33'sd6},
		'{ROW_CFG,  32'd2,         1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd10,        1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd20,        1'b0, 1'b1, 33'sd30},
		'{ROW_ITEM, 32'd1,         1'b0, 1'b1, 33'sd21},
		// above the maximum saturates, so two samples give nothing
		'{ROW_CFG,  32'd127,       1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'ha5a5_a5a5, 1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'h5a5a_5a5a, 1'b0, 1'b0, 33'sd0},
		'{ROW_CFG,  32'd4,         1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'hffff_fffd, 1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd8,         1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd2,         1'b0, 1'b0, 33'sd0},
		'{ROW_ITEM, 32'd6,         1'b0, 1'b1, 33'sd8},
		'{ROW_ITEM, 32'd6,         1'b0, 1'b1, 33'sd12},
		'{ROW_ITEM, 32'd8,         1'b0, 1'b1, 33'sd12}
	};

	logic                       clk;
	logic                       arst_n       = 1'b0;
	logic                       cfg_wen      = 1'b0;
	logic [CFG_W-1:0]           cfg_wdata    = '0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic [SAMPLE_W-1:0]        sample       = '0;
	logic                       first_sample = 1'b0;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic signed [MEDIAN_W-1:0] median_times_two;

	// predictor state
	logic [CFG_W-1:0]           win_size = CFG_W'(WINDOW_SIZE_RST);
	logic signed [SAMPLE_W-1:0] win_ring   [WINDOW_MAX_DEF];
	logic signed [SAMPLE_W-1:0] win_sorted [WINDOW_MAX_DEF];
	int                         win_fill = 0;
	int                         win_ptr  = 0;

	logic signed [MEDIAN_W-1:0] median_q [$];
	int                         mismatches  = 0;
	int                         burst_left  = 0;
	int                         idle_cycles = 0;
	int                         stall_span  = 0;
	stall_mode_t                stall_mode  = STALL_NONE;

	sliding_window_median_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.first_sample     (first_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.median_times_two (median_times_two)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_window(input logic [CFG_W-1:0] w);
		if (w == 0)
			return 1;
		if (w > WINDOW_MAX_DEF)
			return WINDOW_MAX_DEF;
		return int'(w);
	endfunction

	function automatic void sorted_place(input int n, input logic signed [SAMPLE_W-1:0] v);
		int i;
		i = n;
		while (i > 0 && win_sorted[i-1] > v) begin
			win_sorted[i] = win_sorted[i-1];
			i--;
		end
		win_sorted[i] = v;
	endfunction

	function automatic void median_step(input logic signed [SAMPLE_W-1:0] s, input logic first,
			output bit yields, output logic signed [MEDIAN_W-1:0] twice_med);
		int k;
		int i;
		logic signed [MEDIAN_W-1:0] lo;
		logic signed [MEDIAN_W-1:0] hi;
		k = eff_window(win_size);
		if (first) begin
			win_fill = 0;
			win_ptr  = 0;
		end
		if (win_fill > k)
			win_fill = k;
		if (win_ptr >= k)
			win_ptr = 0;
		if (win_fill < k) begin
			sorted_place(win_fill, s);
			win_fill++;
		end else begin
			// drop one copy of the oldest sample, then place the new one
			i = 0;
			while (i < k && win_sorted[i] != win_ring[win_ptr])
				i++;
			for (; i + 1 < k; i++)
				win_sorted[i] = win_sorted[i+1];
			sorted_place(k - 1, s);
		end
		win_ring[win_ptr] = s;
		win_ptr++;
		if (win_ptr >= k)
			win_ptr = 0;
		yields = (win_fill >= k);
		lo = MEDIAN_W'(win_sorted[k/2 - ((k % 2 == 0) ? 1 : 0)]);
		hi = MEDIAN_W'(win_sorted[k/2]);
		twice_med = lo + hi;
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			1, 2, 3: return $urandom_range(0, 16) - 32'd8;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic f, input logic pinned,
			input logic signed [MEDIAN_W-1:0] want);
		int gap;
		bit yields;
		logic signed [MEDIAN_W-1:0] twice_med;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) begin
					sample       <= $urandom;
					first_sample <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
		end
		burst_left--;
		in_valid     <= 1'b1;
		sample       <= s;
		first_sample <= f;
		do @(posedge clk); while (in_stall !== 1'b0);
		median_step($signed(s), f, yields, twice_med);
		if (pinned)
			median_q.push_back(want);
		else if (yields)
			median_q.push_back(twice_med);
	endtask

	task automatic write_window(input logic [CFG_W-1:0] w);
		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		// let a sample that yields nothing finish its passes
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		win_size   = w;
		win_fill   = 0;
		win_ptr    = 0;
		burst_left = 0;
	endtask

	// receiver stall pattern, changing character from one random-length span to the next
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_span = $urandom_range(20, 80);
		end
		stall_span--;
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
			STALL_TOGGLE: out_stall <= stall_span[2];
			default:      out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		logic signed [MEDIAN_W-1:0] want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (median_q.size() == 0) begin
				mismatches++;
				if (mismatches <= PRINT_LIMIT)
					$display("%0t ns: median_times_two expected none, actual %0d",
						$time, median_times_two);
			end else begin
				want = median_q.pop_front();
				if (median_times_two !== want) begin
					mismatches++;
					if (mismatches <= PRINT_LIMIT)
						$display("%0t ns: median_times_two expected %0d, actual %0d",
							$time, want, median_times_two);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [CFG_W-1:0] w;
		int n;
		int k;
		int sent;
		int phase;
		sent  = 0;
		phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_N; r++) begin
			if (DIR_ROWS[r].kind == ROW_CFG)
				write_window(DIR_ROWS[r].value[CFG_W-1:0]);
			else
				send_sample(DIR_ROWS[r].value, DIR_ROWS[r].first, DIR_ROWS[r].pinned,
					DIR_ROWS[r].want);
		end

		// two long phases at the largest window, then mostly small windows
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: begin
					w = CFG_W'(WINDOW_MAX_DEF);
					n = 100;
				end
				1: begin
					w = 7'd127;
					n = 80;
				end
				default: begin
					case ($urandom_range(0, 9))
						0:       w = 7'd0;
						1:       w = CFG_W'($urandom_range(13, 40));
						default: w = CFG_W'($urandom_range(1, 12));
					endcase
					n = eff_window(w) + $urandom_range(8, 30);
				end
			endcase
			write_window(w);
			k = eff_window(w);
			repeat (n)
				send_sample(random_sample(), (k <= 12) && ($urandom_range(0, 15) == 0),
					1'b0, '0);
			sent += n;
			phase++;
		end

		in_valid <= 1'b0;
		while (median_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES + 2) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
